/* hdl/fcbf_pkg.sv */
package fcbf_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = 7;
    localparam int SUM_W = CNT_W + 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_PEEK  = 3'd1;
    localparam logic [2:0] ACT_POP   = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_END   = 3'd4;

    typedef struct packed {
        logic [2:0]       action;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] length;
    } t_fifo_in;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             last;
        logic             write_accepted;
        logic [CNT_W-1:0] buffered_count;
        logic [CNT_W-1:0] space_left;
        logic [31:0]      total_written;
        logic [31:0]      total_read;
        logic             input_closed;
        logic             stream_done;
    } t_fifo_res;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

/* hdl/flow_controlled_byte_fifo_unit.sv */
// Byte FIFO with capacity limit; results appear in the cycle after the command is taken.
// Write, pop, end input and empty requests: one result, next command accepted every cycle.
// Peek/read of n bytes (length capped at the fill): n results on consecutive cycles,
// one store read per cycle; busy stays high until the last store read is issued.
// Synchronous active-low reset clears pointers, count, totals and flags; capacity resets
// to 64; store contents are not cleared. The receiver cannot stall.
module flow_controlled_byte_fifo_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  fcbf_pkg::t_fifo_in      i_in,
    output logic                    o_res_valid,
    output fcbf_pkg::t_fifo_res     o_res,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [fcbf_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int PW = fcbf_pkg::PTR_W;
    localparam int CW = fcbf_pkg::CNT_W;
    localparam int SW = fcbf_pkg::SUM_W;

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic [31:0]   r_tot_wr, n_tot_wr;
    logic [31:0]   r_tot_rd, n_tot_rd;
    logic          r_ended, n_ended;
    logic [CW-1:0] r_cap;
    logic          r_busy, n_busy;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_remain, n_remain;
    logic          r_res_valid, n_res_valid;
    logic          r_last, n_last;
    logic          r_wr_ok, n_wr_ok;
    logic          r_from_ram, n_from_ram;

    logic          accept;
    logic [CW-1:0] eff_cap;
    logic [CW-1:0] space;
    logic [CW-1:0] nsel;
    logic [SW-1:0] head_sum;
    logic [PW-1:0] head_adv;
    logic          mem_we;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_q;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    assign eff_cap  = (r_cap > fcbf_pkg::DEPTH_CNT) ? fcbf_pkg::DEPTH_CNT : r_cap;
    assign space    = (r_fill >= eff_cap) ? '0 : eff_cap - r_fill;
    assign nsel     = (i_in.length < r_fill) ? i_in.length : r_fill;
    assign head_sum = SW'(r_head) + SW'(nsel);
    assign head_adv = (head_sum >= SW'(fcbf_pkg::DEPTH))
                      ? PW'(head_sum - SW'(fcbf_pkg::DEPTH)) : PW'(head_sum);

    assign mem_we    = accept && (i_in.action == fcbf_pkg::ACT_WRITE) && (space != '0);
    assign mem_raddr = r_busy ? r_rd_ptr : r_head;

    fcbf_ram #(
        .DEPTH  (fcbf_pkg::DEPTH),
        .WIDTH  (8),
        .ADDR_W (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (i_in.data_byte),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_tot_wr    = r_tot_wr;
        n_tot_rd    = r_tot_rd;
        n_ended     = r_ended;
        n_busy      = r_busy;
        n_rd_ptr    = r_rd_ptr;
        n_remain    = r_remain;
        n_res_valid = 1'b0;
        n_last      = 1'b1;
        n_wr_ok     = 1'b0;
        n_from_ram  = 1'b0;
        if (r_busy) begin
            n_res_valid = 1'b1;
            n_from_ram  = 1'b1;
            n_last      = (r_remain == CW'(1));
            n_busy      = (r_remain > CW'(1));
            n_remain    = r_remain - CW'(1);
            n_rd_ptr    = fcbf_pkg::next_ptr(r_rd_ptr);
        end else if (accept) begin
            n_res_valid = 1'b1;
            unique case (i_in.action)
                fcbf_pkg::ACT_WRITE: begin
                    if (space != '0) begin
                        n_wr_ok  = 1'b1;
                        n_tail   = fcbf_pkg::next_ptr(r_tail);
                        n_fill   = r_fill + CW'(1);
                        n_tot_wr = r_tot_wr + 32'd1;
                    end
                end
                fcbf_pkg::ACT_PEEK, fcbf_pkg::ACT_READ: begin
                    if (nsel != '0) begin
                        n_from_ram = 1'b1;
                        n_last     = (nsel == CW'(1));
                        n_busy     = (nsel > CW'(1));
                        n_remain   = nsel - CW'(1);
                        n_rd_ptr   = fcbf_pkg::next_ptr(r_head);
                    end
                    if (i_in.action == fcbf_pkg::ACT_READ) begin
                        n_head   = head_adv;
                        n_fill   = r_fill - nsel;
                        n_tot_rd = r_tot_rd + 32'(nsel);
                    end
                end
                fcbf_pkg::ACT_POP: begin
                    n_head   = head_adv;
                    n_fill   = r_fill - nsel;
                    n_tot_rd = r_tot_rd + 32'(nsel);
                end
                fcbf_pkg::ACT_END: begin
                    n_ended = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_tot_wr    <= '0;
            r_tot_rd    <= '0;
            r_ended     <= 1'b0;
            r_cap       <= fcbf_pkg::CAP_RESET;
            r_busy      <= 1'b0;
            r_rd_ptr    <= '0;
            r_remain    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_tot_wr    <= n_tot_wr;
            r_tot_rd    <= n_tot_rd;
            r_ended     <= n_ended;
            r_busy      <= n_busy;
            r_rd_ptr    <= n_rd_ptr;
            r_remain    <= n_remain;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_wr_ok    <= n_wr_ok;
        r_from_ram <= n_from_ram;
    end

    // status fields reflect the state after the step; state is frozen until the
    // last result of an item has been shown
    assign o_res_valid          = r_res_valid;
    assign o_res.out_byte       = r_from_ram ? mem_q : 8'd0;
    assign o_res.byte_valid     = r_from_ram;
    assign o_res.last           = r_last;
    assign o_res.write_accepted = r_wr_ok;
    assign o_res.buffered_count = r_fill;
    assign o_res.space_left     = space;
    assign o_res.total_written  = r_tot_wr;
    assign o_res.total_read     = r_tot_rd;
    assign o_res.input_closed   = r_ended;
    assign o_res.stream_done    = r_ended && (r_fill == '0);

endmodule

/* hdl/fcbf_ram.sv */
module fcbf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
